FILE: src/kmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmc_pkg
// Shared constants and types of the k-means nearest-centroid block.
// ----------------------------------------------------------------------------
package kmc_pkg;

  localparam int MAX_CLUSTERS = 16;
  localparam int MAX_FEATURES = 32;
  localparam int CL_W   = 4;
  localparam int FT_W   = 5;
  localparam int K_W    = 5;
  localparam int DIST_W = 48;
  localparam int ADDR_W = CL_W + FT_W;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef enum logic [1:0] {
    OP_CENT  = 2'd0,
    OP_STAT  = 2'd1,
    OP_CLASS = 2'd2
  } op_e;

  localparam logic [1:0] FUNC_CENT  = 2'd0;
  localparam logic [1:0] FUNC_STAT  = 2'd1;
  localparam logic [1:0] FUNC_CLASS = 2'd2;

  typedef struct packed {
    op_e              op;
    logic [CL_W-1:0]  cluster_index;
    logic [FT_W-1:0]  feature_index;
    logic [31:0]      value;
    logic [31:0]      spread;
    logic [15:0]      weight;
    logic             counts;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic not_empty;
    cmd_t head;
  } queue_t;

endpackage

FILE: src/kmc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: src/kmc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmc_front
// Accepts items, decodes and range-checks them and queues commands.
// ----------------------------------------------------------------------------
module kmc_front import kmc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [1:0]       func_i,
  input  logic [CL_W-1:0]  cluster_index_i,
  input  logic [FT_W-1:0]  feature_index_i,
  input  logic [31:0]      value_i,
  input  logic [31:0]      spread_i,
  input  logic [15:0]      weight_i,
  input  logic             missing_i,
  input  logic             last_i,
  input  logic             pop_i,
  output queue_t           queue_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  cmd_t       cmd;
  logic       keep;
  logic       push;
  logic       ci_ok, fi_ok;

  assign ci_ok = 32'(cluster_index_i) < MAX_CLUSTERS;
  assign fi_ok = 32'(feature_index_i) < MAX_FEATURES;

  always_comb begin
    cmd.cluster_index = cluster_index_i;
    cmd.feature_index = feature_index_i;
    cmd.value         = value_i;
    cmd.spread        = spread_i;
    cmd.weight        = weight_i;
    cmd.last          = last_i;
    cmd.counts        = fi_ok && !missing_i;
    cmd.op            = OP_CLASS;
    keep              = 1'b0;
    case (func_i)
      FUNC_CENT: begin
        cmd.op = OP_CENT;
        keep   = ci_ok && fi_ok;
      end
      FUNC_STAT: begin
        cmd.op = OP_STAT;
        keep   = fi_ok;
      end
      FUNC_CLASS: begin
        cmd.op = OP_CLASS;
        keep   = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign busy_o = count_q == 2'd2;
  assign push   = start_i && !busy_o && keep;

  assign queue_o.not_empty = count_q != 2'd0;
  assign queue_o.head      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= cmd;
  end

endmodule

FILE: src/kmc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmc_back
// Executes queued commands: table writes, normalization divide,
// per-cluster multiply-accumulate and the nearest-cluster search.
// ----------------------------------------------------------------------------
module kmc_back import kmc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  queue_t            queue_i,
  output logic              pop_o,
  input  logic [K_W-1:0]    k_i,
  output logic              done_o,
  output logic [K_W-1:0]    nearest_cluster_o,
  output logic [DIST_W-1:0] distance_o
);

  localparam int DIV_W = 49;
  localparam int DCNT_W = $clog2(DIV_W + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_NORM = 4'd3;
  localparam logic [3:0] S_RD   = 4'd4;
  localparam logic [3:0] S_SQ   = 4'd5;
  localparam logic [3:0] S_WT   = 4'd6;
  localparam logic [3:0] S_ACC  = 4'd7;
  localparam logic [3:0] S_LAST = 4'd8;
  localparam logic [3:0] S_FIND = 4'd9;

  logic [3:0]        state_q;
  cmd_t              cmd_q;
  logic [31:0]       mean_q   [MAX_FEATURES];
  logic [31:0]       spread_q [MAX_FEATURES];
  logic [15:0]       weight_q [MAX_FEATURES];
  logic [DIST_W-1:0] acc_q    [MAX_CLUSTERS];
  logic [K_W-1:0]    c_q;
  logic [CL_W-1:0]   best_q;
  logic [DIST_W-1:0] best_dist_q;
  logic              neg_q;
  logic [DIV_W-1:0]  quo_q;
  logic [32:0]       rem_q;
  logic [31:0]       div_q;
  logic [DCNT_W-1:0] dcnt_q;
  logic [31:0]       norm_q;
  logic [15:0]       w_q;
  logic [63:0]       sq_q;
  logic [63:0]       prod_q;
  logic              done_q;
  logic [K_W-1:0]    res_cl_q;
  logic [DIST_W-1:0] res_dist_q;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_raddr;
  logic [31:0]       ram_rdata;

  logic [32:0]       diff;
  logic [32:0]       mag;
  logic [33:0]       rem_sh;
  logic [32:0]       d;
  logic [31:0]       m;
  logic [55:0]       term_full;
  logic [DIST_W-1:0] term;
  logic [DIST_W:0]   acc_sum;
  logic [DIST_W-1:0] acc_new;
  logic [15:0]       cur_w;

  assign cur_w = weight_q[cmd_q.feature_index];
  assign diff  = {cmd_q.value[31], cmd_q.value}
               - {mean_q[cmd_q.feature_index][31], mean_q[cmd_q.feature_index]};
  assign mag   = diff[32] ? 33'(-diff) : diff;
  assign rem_sh = {rem_q, quo_q[DIV_W-1]};
  assign d     = {ram_rdata[31], ram_rdata} - {norm_q[31], norm_q};
  assign m     = d[32] ? 32'(-d) : d[31:0];
  assign term_full = prod_q[63:8];
  assign term  = (term_full[55:DIST_W] != '0) ? DIST_MAX : term_full[DIST_W-1:0];
  assign acc_sum = {1'b0, acc_q[c_q[CL_W-1:0]]} + {1'b0, term};
  assign acc_new = acc_sum[DIST_W] ? DIST_MAX : acc_sum[DIST_W-1:0];

  assign pop_o     = (state_q == S_IDLE) && queue_i.not_empty;
  assign ram_we    = (state_q == S_DISP) && (cmd_q.op == OP_CENT);
  assign ram_raddr = {c_q[CL_W-1:0], cmd_q.feature_index};

  kmc_ram #(.WIDTH(32), .DEPTH(MAX_CLUSTERS * MAX_FEATURES)) u_centroids (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i ({cmd_q.cluster_index, cmd_q.feature_index}),
    .wdata_i (cmd_q.value),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      c_q     <= '0;
      for (int i = 0; i < MAX_FEATURES; i++) weight_q[i] <= '0;
      for (int i = 0; i < MAX_CLUSTERS; i++) acc_q[i] <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (queue_i.not_empty) state_q <= S_DISP;
        end
        S_DISP: begin
          c_q <= '0;
          case (cmd_q.op)
            OP_STAT: begin
              weight_q[cmd_q.feature_index] <= cmd_q.weight;
              state_q <= S_IDLE;
            end
            OP_CLASS: begin
              if (cmd_q.counts && cur_w != '0) begin
                state_q <= (spread_q[cmd_q.feature_index] == '0) ? S_RD : S_DIV;
              end else begin
                state_q <= S_LAST;
              end
            end
            default: state_q <= S_IDLE;
          endcase
        end
        S_DIV: begin
          if (dcnt_q == DCNT_W'(1)) state_q <= S_NORM;
        end
        S_NORM: state_q <= S_RD;
        S_RD:   state_q <= S_SQ;
        S_SQ:   state_q <= S_WT;
        S_WT:   state_q <= S_ACC;
        S_ACC: begin
          acc_q[c_q[CL_W-1:0]] <= acc_new;
          if (c_q + K_W'(1) >= k_i) begin
            state_q <= S_LAST;
          end else begin
            c_q     <= c_q + K_W'(1);
            state_q <= S_RD;
          end
        end
        S_LAST: begin
          c_q     <= K_W'(1);
          state_q <= cmd_q.last ? S_FIND : S_IDLE;
        end
        S_FIND: begin
          if (c_q >= k_i) begin
            done_q  <= 1'b1;
            for (int i = 0; i < MAX_CLUSTERS; i++) acc_q[i] <= '0;
            state_q <= S_IDLE;
          end else begin
            c_q <= c_q + K_W'(1);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (pop_o) cmd_q <= queue_i.head;
    if (state_q == S_DISP && cmd_q.op == OP_STAT) begin
      mean_q[cmd_q.feature_index]   <= cmd_q.value;
      spread_q[cmd_q.feature_index] <= cmd_q.spread;
    end
    case (state_q)
      S_DISP: begin
        neg_q  <= diff[32];
        quo_q  <= {mag, 16'd0};
        rem_q  <= '0;
        div_q  <= spread_q[cmd_q.feature_index];
        dcnt_q <= DCNT_W'(DIV_W);
        norm_q <= '0;
        w_q    <= cur_w;
      end
      S_DIV: begin
        // restoring divide, one quotient bit per cycle
        if (rem_sh >= {2'b00, div_q}) begin
          rem_q <= 33'(rem_sh - {2'b00, div_q});
          quo_q <= {quo_q[DIV_W-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh[32:0];
          quo_q <= {quo_q[DIV_W-2:0], 1'b0};
        end
        dcnt_q <= dcnt_q - DCNT_W'(1);
      end
      S_NORM: begin
        if (neg_q) begin
          norm_q <= (quo_q > DIV_W'(33'h080000000)) ? 32'h80000000
                                                    : 32'(-quo_q[31:0]);
        end else begin
          norm_q <= (quo_q > DIV_W'(33'h07FFFFFFF)) ? 32'h7FFFFFFF : quo_q[31:0];
        end
      end
      S_SQ: sq_q <= m * m;
      S_WT: prod_q <= sq_q[63:16] * w_q;
      S_LAST: begin
        best_q      <= '0;
        best_dist_q <= acc_q[0];
      end
      S_FIND: begin
        if (c_q < k_i) begin
          if (acc_q[c_q[CL_W-1:0]] < best_dist_q) begin
            best_q      <= c_q[CL_W-1:0];
            best_dist_q <= acc_q[c_q[CL_W-1:0]];
          end
        end else begin
          res_cl_q   <= K_W'(best_q) + K_W'(1);
          res_dist_q <= best_dist_q;
        end
      end
      default: ;
    endcase
  end

  assign done_o            = done_q;
  assign nearest_cluster_o = res_cl_q;
  assign distance_o        = res_dist_q;

endmodule

FILE: src/kmeans_nearest_centroid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmeans_nearest_centroid
// Nearest-centroid assignment for k-means, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// channel   handshake            payload
// input     start_i / busy_o     func, cluster/feature index, value, spread,
//                                weight, missing, last
// config    cfg_we_i             cfg_data_i (cluster count)
// result    done_o (one cycle)   nearest_cluster_o, distance_o
//
// Load items pass through pop and dispatch in the back end. A counting
// classify item passes through pop, dispatch, the bit-serial spread divide
// and a saturation step (both skipped when the spread is zero), centroid read,
// square, weight and accumulate for each cluster, and a closing step; a
// non-counting classify item has only pop, dispatch and closing. A last item
// then adds the minimum search, and done_o is registered from it. A two-entry command
// queue decouples intake from execution; busy_o is high while it is full.
// Reset clears weights, accumulators and the cluster count (1).
// The result receiver cannot stall.
// ----------------------------------------------------------------------------
module kmeans_nearest_centroid import kmc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [1:0]        func_i,
  input  logic [CL_W-1:0]   cluster_index_i,
  input  logic [FT_W-1:0]   feature_index_i,
  input  logic [31:0]       value_i,
  input  logic [31:0]       spread_i,
  input  logic [15:0]       weight_i,
  input  logic              missing_i,
  input  logic              last_i,
  input  logic              cfg_we_i,
  input  logic [K_W-1:0]    cfg_data_i,
  output logic              done_o,
  output logic [K_W-1:0]    nearest_cluster_o,
  output logic [DIST_W-1:0] distance_o
);

  logic [K_W-1:0] cluster_count_q;
  logic [K_W-1:0] k;
  queue_t         queue;
  logic           pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cluster_count_q <= K_W'(1);
    end else if (cfg_we_i) begin
      cluster_count_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (cluster_count_q == '0) k = K_W'(1);
    else if (32'(cluster_count_q) > MAX_CLUSTERS) k = K_W'(MAX_CLUSTERS);
    else k = cluster_count_q;
  end

  kmc_front u_front (
    .clk_i, .rst_ni, .start_i, .busy_o, .func_i, .cluster_index_i,
    .feature_index_i, .value_i, .spread_i, .weight_i, .missing_i, .last_i,
    .pop_i   (pop),
    .queue_o (queue)
  );

  kmc_back u_back (
    .clk_i, .rst_ni,
    .queue_i (queue),
    .pop_o   (pop),
    .k_i     (k),
    .done_o, .nearest_cluster_o, .distance_o
  );

  a_cluster_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (nearest_cluster_o != '0 && nearest_cluster_o <= k))
    else $error("nearest cluster outside 1..k");

  a_no_double_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two results in consecutive cycles");

  a_busy_needs_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> queue.not_empty)
    else $error("busy with an empty queue");

endmodule

FILE: dv/kmeans_nearest_centroid_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmeans_nearest_centroid_tb
// Self-checking bench for the nearest-centroid block: a queue-fed driver
// pushes load and classify commands, a predictor computes the nearest
// cluster and distance per instance, and a monitor checks every result.
// ----------------------------------------------------------------------------
module kmeans_nearest_centroid_tb import kmc_pkg::*; ();

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 600;
  localparam int PHASE_ITEMS   = 222;

  typedef struct {
    logic [1:0]      func;
    logic [CL_W-1:0] cluster_index;
    logic [FT_W-1:0] feature_index;
    logic [31:0]     value;
    logic [31:0]     spread;
    logic [15:0]     weight;
    logic            missing;
    logic            last;
  } cmd_item_t;

  typedef struct {
    logic [K_W-1:0]    cluster;
    logic [DIST_W-1:0] distance;
  } assignment_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic [1:0]        func_i = '0;
  logic [CL_W-1:0]   cluster_index_i = '0;
  logic [FT_W-1:0]   feature_index_i = '0;
  logic [31:0]       value_i = '0;
  logic [31:0]       spread_i = '0;
  logic [15:0]       weight_i = '0;
  logic              missing_i = 1'b0;
  logic              last_i = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [K_W-1:0]    cfg_data_i = '0;
  logic              done_o;
  logic [K_W-1:0]    nearest_cluster_o;
  logic [DIST_W-1:0] distance_o;

  kmeans_nearest_centroid dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  cmd_item_t   pending_cmds[$];
  assignment_t expected_assignments[$];
  cmd_item_t   cur_cmd;
  int          sender_idle_pct = 0;
  int          mismatches = 0;
  int          gen_items = 0;

  // predictor state
  logic [31:0]       mdl_centroid[MAX_CLUSTERS*MAX_FEATURES];
  logic [31:0]       mdl_mean[MAX_FEATURES];
  logic [31:0]       mdl_spread[MAX_FEATURES];
  logic [15:0]       mdl_weight[MAX_FEATURES];
  logic [DIST_W-1:0] mdl_acc[MAX_CLUSTERS];
  logic [K_W-1:0]    mdl_k;

  // stimulus-side view, used to keep classify reads on written centroids
  logic [15:0] gen_weight[MAX_FEATURES];
  bit          gen_cent_written[MAX_CLUSTERS][MAX_FEATURES];
  int          gen_k;

  function automatic int eff_k(logic [K_W-1:0] k);
    if (k == 0) return 1;
    if (k > MAX_CLUSTERS) return MAX_CLUSTERS;
    return int'(k);
  endfunction

  function automatic longint normalize_value(longint diff, logic [31:0] sd);
    logic [63:0] mag, q;
    if (sd == 0) return 0;
    mag = (diff < 0) ? 64'(-diff) : 64'(diff);
    q = (mag << 16) / {32'd0, sd};
    if (diff < 0) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return -longint'(q);
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return longint'(q);
  endfunction

  task automatic predict_assignment(cmd_item_t it);
    int          k, best;
    longint      norm, d;
    logic [63:0] m, sq, term, acc;
    assignment_t res;
    k = eff_k(mdl_k);
    case (it.func)
      FUNC_CENT: mdl_centroid[it.cluster_index*MAX_FEATURES + it.feature_index] = it.value;
      FUNC_STAT: begin
        mdl_mean[it.feature_index]   = it.value;
        mdl_spread[it.feature_index] = it.spread;
        mdl_weight[it.feature_index] = it.weight;
      end
      FUNC_CLASS: begin
        if (mdl_weight[it.feature_index] != 0 && !it.missing) begin
          norm = normalize_value(longint'($signed(it.value))
                 - longint'($signed(mdl_mean[it.feature_index])),
                 mdl_spread[it.feature_index]);
          for (int c = 0; c < k; c++) begin
            d = longint'($signed(mdl_centroid[c*MAX_FEATURES + it.feature_index])) - norm;
            m = (d < 0) ? 64'(-d) : 64'(d);
            sq = (m * m) >> 16;
            term = (sq * {48'd0, mdl_weight[it.feature_index]}) >> 8;
            if (term > {16'd0, DIST_MAX}) term = {16'd0, DIST_MAX};
            acc = {16'd0, mdl_acc[c]} + term;
            if (acc > {16'd0, DIST_MAX}) acc = {16'd0, DIST_MAX};
            mdl_acc[c] = acc[DIST_W-1:0];
          end
        end
        if (it.last) begin
          best = 0;
          for (int c = 1; c < k; c++)
            if (mdl_acc[c] < mdl_acc[best]) best = c;
          res.cluster = K_W'(best + 1);
          res.distance = mdl_acc[best];
          expected_assignments.insert(expected_assignments.size(), res);
          for (int c = 0; c < MAX_CLUSTERS; c++) mdl_acc[c] = '0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string msg);
    $display("%0t ERROR: %s", $time, msg);
    mismatches++;
  endtask

  // driver: hold while the block is busy, otherwise present the next command
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) predict_assignment(cur_cmd);
      if (start_i && busy_o) begin
      end else if (pending_cmds.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        cur_cmd = pending_cmds.pop_front();
        start_i         <= 1'b1;
        func_i          <= cur_cmd.func;
        cluster_index_i <= cur_cmd.cluster_index;
        feature_index_i <= cur_cmd.feature_index;
        value_i         <= cur_cmd.value;
        spread_i        <= cur_cmd.spread;
        weight_i        <= cur_cmd.weight;
        missing_i       <= cur_cmd.missing;
        last_i          <= cur_cmd.last;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor: one result transfer per done cycle
  always @(posedge clk_i) begin
    assignment_t exp_res;
    if (rst_ni && done_o) begin
      if (expected_assignments.size() == 0) begin
        report_mismatch($sformatf("unexpected result cluster %0d distance %0h",
                        nearest_cluster_o, distance_o));
      end else begin
        exp_res = expected_assignments.pop_front();
        if (nearest_cluster_o !== exp_res.cluster)
          report_mismatch($sformatf("nearest_cluster %0d, expected %0d",
                          nearest_cluster_o, exp_res.cluster));
        if (distance_o !== exp_res.distance)
          report_mismatch($sformatf("distance %0h, expected %0h",
                          distance_o, exp_res.distance));
      end
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      default: return $urandom_range(32'h6_0000) - 32'h3_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_spread();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2, 3: return $urandom;
      default: return $urandom_range(32'h4_0000, 32'h4000);
    endcase
  endfunction

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(16'h300, 1));
    endcase
  endfunction

  task automatic push_cmd(logic [1:0] func, int ci, int fi, logic [31:0] val,
                          logic [31:0] sd, logic [15:0] w, bit miss, bit lst);
    cmd_item_t it;
    it.func = func;
    it.cluster_index = CL_W'(ci);
    it.feature_index = FT_W'(fi);
    it.value = val;
    it.spread = sd;
    it.weight = w;
    it.missing = miss;
    it.last = lst;
    if (func == FUNC_CENT) gen_cent_written[ci][fi] = 1'b1;
    if (func == FUNC_STAT) gen_weight[fi] = w;
    pending_cmds.insert(pending_cmds.size(), it);
    gen_items++;
  endtask

  // a counting feature reads every active centroid of that feature
  task automatic push_classify(int fi, logic [31:0] val, bit miss, bit lst);
    if (gen_weight[fi] != 0)
      for (int c = 0; c < gen_k; c++)
        if (!gen_cent_written[c][fi])
          push_cmd(FUNC_CENT, c, fi, pick_value(), $urandom, 16'($urandom), 1'b0, 1'b0);
    push_cmd(FUNC_CLASS, $urandom_range(15), fi, val, $urandom, 16'($urandom),
             miss, lst);
  endtask

  task automatic fill_phase();
    int n_end, n_feat;
    n_end = gen_items + PHASE_ITEMS;
    while (gen_items < n_end) begin
      case ($urandom_range(99)) inside
        [0:69]: begin
          n_feat = $urandom_range(6, 1);
          for (int j = 0; j < n_feat; j++)
            push_classify($urandom_range(31), pick_value(), $urandom_range(9) == 0,
                          j == n_feat - 1);
        end
        [70:79]: begin
          push_cmd(FUNC_STAT, $urandom_range(15), $urandom_range(31), pick_value(),
                   pick_spread(), pick_weight(), $urandom_range(1), $urandom_range(1));
        end
        [80:87]: begin
          push_cmd(FUNC_CENT, $urandom_range(15), $urandom_range(31), pick_value(),
                   $urandom, 16'($urandom), $urandom_range(1), $urandom_range(1));
        end
        [88:94]: push_cmd(FUNC_UNUSED, $urandom_range(15), $urandom_range(31),
                          $urandom, $urandom, 16'($urandom), $urandom_range(1),
                          $urandom_range(1));
        default: begin
          // broken instance: classify with random last, usually not closed
          push_classify($urandom_range(31), $urandom, $urandom_range(1),
                        $urandom_range(3) == 0);
        end
      endcase
    end
  endtask

  task automatic drain();
    wait (pending_cmds.size() == 0 && !start_i);
    wait (expected_assignments.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cluster_count(logic [K_W-1:0] k);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= k;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mdl_k = k;
    gen_k = eff_k(k);
  endtask

  initial begin
    logic [K_W-1:0] k_plan[6];
    for (int i = 0; i < MAX_CLUSTERS*MAX_FEATURES; i++) mdl_centroid[i] = '0;
    for (int f = 0; f < MAX_FEATURES; f++) begin
      mdl_mean[f] = '0;
      mdl_spread[f] = '0;
      mdl_weight[f] = '0;
      gen_weight[f] = '0;
    end
    for (int c = 0; c < MAX_CLUSTERS; c++) mdl_acc[c] = '0;
    mdl_k = 1;
    gen_k = 1;
    k_plan = '{5'd16, 5'd1, 5'd7, 5'd0, 5'd31, K_W'($urandom_range(15, 2))};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero spread, zero weight, saturating normalize, missing, no feature
    sender_idle_pct = 20;
    push_cmd(FUNC_STAT, 0, 0, 32'h0001_0000, 32'd0, 16'h0100, 1'b0, 1'b0);
    push_cmd(FUNC_STAT, 0, 1, 32'h7FFF_FFFF, 32'h0001_0000, 16'd0, 1'b0, 1'b0);
    push_cmd(FUNC_STAT, 0, 2, 32'h8000_0000, 32'd1, 16'hFFFF, 1'b0, 1'b0);
    push_cmd(FUNC_STAT, 0, 3, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'd1, 1'b0, 1'b0);
    push_cmd(FUNC_CENT, 0, 0, 32'h7FFF_FFFF, 32'd0, 16'd0, 1'b0, 1'b0);
    push_cmd(FUNC_CENT, 0, 2, 32'h8000_0000, 32'd0, 16'd0, 1'b0, 1'b0);
    push_cmd(FUNC_CENT, 0, 3, 32'h0000_0000, 32'd0, 16'd0, 1'b0, 1'b0);
    push_classify(0, 32'h7FFF_FFFF, 1'b0, 1'b0);
    push_classify(1, 32'h8000_0000, 1'b0, 1'b0);
    push_classify(3, 32'h8000_0000, 1'b0, 1'b1);
    push_classify(2, 32'h7FFF_FFFF, 1'b0, 1'b0);
    push_classify(2, 32'h7FFF_FFFF, 1'b0, 1'b1);
    push_classify(0, 32'h1234_5678, 1'b1, 1'b1);
    push_cmd(FUNC_UNUSED, 15, 31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1);
    push_classify(31, 32'd0, 1'b0, 1'b1);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_cluster_count(k_plan[p]);
      sender_idle_pct = (p < 2) ? 20 : (p < 4) ? 83 : 0;
      fill_phase();
      drain();
    end

    if (mismatches == 0 && expected_assignments.size() == 0) begin
      $display("kmeans_nearest_centroid_tb passed");
    end else begin
      $display("kmeans_nearest_centroid_tb failed");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("kmeans_nearest_centroid_tb failed");
    $finish;
  end

endmodule

FILE: filelist.f
src/kmc_pkg.sv
src/kmc_ram.sv
src/kmc_front.sv
src/kmc_back.sv
src/kmeans_nearest_centroid.sv
dv/kmeans_nearest_centroid_tb.sv
